// ===== sv/cfpp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cfpp_pkg;

  // Body store depth; a legal length byte is 4 .. BODY_DEPTH+2.
  localparam int BODY_DEPTH = 32;
  // Body counter width: holds values up to BODY_DEPTH itself.
  localparam int CNT_W      = $clog2(BODY_DEPTH + 1);
  // Address of one entry inside one bank.
  localparam int AW         = (BODY_DEPTH > 1) ? $clog2(BODY_DEPTH) : 1;
  // Two banks: one filled by the parser, one drained by the emitter.
  localparam int RAM_AW     = AW + 1;
  localparam int RAM_DEPTH  = 2 ** RAM_AW;
  localparam int IDX_W      = 5;
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);
  localparam int CFG_IDX_W  = 2;

  localparam logic [7:0]  SYNC_FIRST  = 8'h55;
  localparam logic [7:0]  SYNC_SECOND = 8'hAA;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;
  localparam logic [7:0]  LEN_MIN     = 8'd4;
  localparam logic [7:0]  LEN_MAX     = 8'(BODY_DEPTH + 2);

  typedef enum logic [2:0] {
    ST_OK   = 3'd0,
    ST_SYNC = 3'd1,
    ST_ID   = 3'd2,
    ST_LEN  = 3'd3,
    ST_CRC  = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REMOTE_HI = 2'd0,
    CFG_REMOTE_LO = 2'd1,
    CFG_SENSOR_HI = 2'd2,
    CFG_SENSOR_LO = 2'd3
  } cfg_reg_e;

  // One entry of the queue between parser and emitter.
  typedef struct packed {
    logic             is_run;
    status_e          status;
    logic             src;
    logic             bank;
    logic [CNT_W-1:0] count;
  } cmd_t;

  typedef struct packed {
    logic              we;
    logic [RAM_AW-1:0] addr;
    logic [7:0]        data;
  } ram_wr_t;

  typedef struct packed {
    logic              re;
    logic [RAM_AW-1:0] addr;
  } ram_rd_t;

  // CRC16-Modbus update by one byte, LSB first, reflected polynomial.
  function automatic logic [15:0] crc_feed(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/cfpp_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cfpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== sv/cfpp_cmd_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cfpp_cmd_fifo (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  cfpp_pkg::cmd_t    push_cmd_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output cfpp_pkg::cmd_t    head_o,
  output logic              empty_o
);

  cfpp_pkg::cmd_t                   mem_q [cfpp_pkg::Q_DEPTH];
  logic [cfpp_pkg::Q_PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [cfpp_pkg::Q_CNT_W-1:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == cfpp_pkg::Q_CNT_W'(cfpp_pkg::Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/cfpp_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cfpp_parser (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [cfpp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [7:0]                     cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [7:0]                     rx_byte_i,
  output logic                                push_o,
  output cfpp_pkg::cmd_t                      push_cmd_o,
  input  wire logic                           q_full_i,
  input  wire logic                           run_done_i,
  output cfpp_pkg::ram_wr_t                   ram_wr_o
);

  typedef enum logic [7:0] {
    PH_HUNT1 = 8'b0000_0001,
    PH_HUNT2 = 8'b0000_0010,
    PH_LEN   = 8'b0000_0100,
    PH_IDH   = 8'b0000_1000,
    PH_IDL   = 8'b0001_0000,
    PH_BODY  = 8'b0010_0000,
    PH_CRCH  = 8'b0100_0000,
    PH_CRCL  = 8'b1000_0000
  } phase_e;

  phase_e                       phase_q, phase_d;
  logic [15:0]                  crc_q, crc_d;
  logic [cfpp_pkg::CNT_W-1:0]   exp_q, exp_d;
  logic [cfpp_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [cfpp_pkg::CNT_W-1:0]   cnt_inc;
  logic [7:0]                   id_hi_q, id_hi_d;
  logic                         src_q, src_d;
  logic [7:0]                   crc_hi_q, crc_hi_d;
  logic                         bank_q, bank_d;
  logic [1:0]                   runs_q, runs_d;
  logic [7:0]                   rem_hi_q, rem_lo_q, sen_hi_q, sen_lo_q;
  logic                         accept;
  logic                         run_push;

  assign cfg_ready_o = 1'b1;
  // Hold input when the queue is full, or a body byte would land in a bank still queued.
  assign in_ready_o  = !q_full_i && !(phase_q == PH_BODY && runs_q == 2'd2);
  assign accept      = in_valid_i && in_ready_o;
  assign cnt_inc     = cnt_q + 1'b1;
  assign run_push    = push_o && push_cmd_o.is_run;

  always_comb begin
    phase_d    = phase_q;
    crc_d      = crc_q;
    exp_d      = exp_q;
    cnt_d      = cnt_q;
    id_hi_d    = id_hi_q;
    src_d      = src_q;
    crc_hi_d   = crc_hi_q;
    push_o     = 1'b0;
    push_cmd_o = '{is_run: 1'b0, status: cfpp_pkg::ST_OK, src: 1'b0, bank: 1'b0, count: '0};
    ram_wr_o   = '{we: 1'b0, addr: {bank_q, cnt_q[cfpp_pkg::AW-1:0]}, data: rx_byte_i};
    if (accept) begin
      case (phase_q)
        PH_HUNT1: begin
          if (rx_byte_i == cfpp_pkg::SYNC_FIRST) begin
            phase_d = PH_HUNT2;
          end
        end
        PH_HUNT2: begin
          if (rx_byte_i == cfpp_pkg::SYNC_SECOND) begin
            phase_d = PH_LEN;
          end else begin
            push_o            = 1'b1;
            push_cmd_o.status = cfpp_pkg::ST_SYNC;
            phase_d           = PH_HUNT1;
          end
        end
        PH_LEN: begin
          if (rx_byte_i < cfpp_pkg::LEN_MIN || rx_byte_i > cfpp_pkg::LEN_MAX) begin
            push_o            = 1'b1;
            push_cmd_o.status = cfpp_pkg::ST_LEN;
            phase_d           = PH_HUNT1;
          end else begin
            crc_d   = cfpp_pkg::crc_feed(cfpp_pkg::CRC_INIT, rx_byte_i);
            exp_d   = cfpp_pkg::CNT_W'(rx_byte_i - 8'd2);
            cnt_d   = '0;
            phase_d = PH_IDH;
          end
        end
        PH_IDH: begin
          id_hi_d = rx_byte_i;
          crc_d   = cfpp_pkg::crc_feed(crc_q, rx_byte_i);
          phase_d = PH_IDL;
        end
        PH_IDL: begin
          // Remote ID wins when both match.
          if (id_hi_q == rem_hi_q && rx_byte_i == rem_lo_q) begin
            src_d   = 1'b0;
            crc_d   = cfpp_pkg::crc_feed(crc_q, rx_byte_i);
            cnt_d   = '0;
            phase_d = PH_BODY;
          end else if (id_hi_q == sen_hi_q && rx_byte_i == sen_lo_q) begin
            src_d   = 1'b1;
            crc_d   = cfpp_pkg::crc_feed(crc_q, rx_byte_i);
            cnt_d   = '0;
            phase_d = PH_BODY;
          end else begin
            push_o            = 1'b1;
            push_cmd_o.status = cfpp_pkg::ST_ID;
            phase_d           = PH_HUNT1;
          end
        end
        PH_BODY: begin
          ram_wr_o.we = 1'b1;
          crc_d       = cfpp_pkg::crc_feed(crc_q, rx_byte_i);
          cnt_d       = cnt_inc;
          if (cnt_inc >= exp_q) begin
            phase_d = PH_CRCH;
          end
        end
        PH_CRCH: begin
          crc_hi_d = rx_byte_i;
          phase_d  = PH_CRCL;
        end
        PH_CRCL: begin
          push_o  = 1'b1;
          phase_d = PH_HUNT1;
          if ({crc_hi_q, rx_byte_i} != crc_q) begin
            push_cmd_o.status = cfpp_pkg::ST_CRC;
          end else begin
            push_cmd_o.is_run = 1'b1;
            push_cmd_o.src    = src_q;
            push_cmd_o.bank   = bank_q;
            push_cmd_o.count  = exp_q;
          end
        end
        default: begin
          phase_d = PH_HUNT1;
        end
      endcase
    end
  end

  // Flip banks on each queued run; count runs not yet fully emitted.
  always_comb begin
    bank_d = bank_q ^ run_push;
    runs_d = runs_q;
    if (run_push && !run_done_i) begin
      runs_d = runs_q + 2'd1;
    end else if (run_done_i && !run_push) begin
      runs_d = runs_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT1;
      crc_q    <= cfpp_pkg::CRC_INIT;
      exp_q    <= '0;
      cnt_q    <= '0;
      id_hi_q  <= '0;
      src_q    <= 1'b0;
      crc_hi_q <= '0;
      bank_q   <= 1'b0;
      runs_q   <= '0;
      rem_hi_q <= '0;
      rem_lo_q <= '0;
      sen_hi_q <= '0;
      sen_lo_q <= '0;
    end else begin
      phase_q  <= phase_d;
      crc_q    <= crc_d;
      exp_q    <= exp_d;
      cnt_q    <= cnt_d;
      id_hi_q  <= id_hi_d;
      src_q    <= src_d;
      crc_hi_q <= crc_hi_d;
      bank_q   <= bank_d;
      runs_q   <= runs_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          cfpp_pkg::CFG_REMOTE_HI: rem_hi_q <= cfg_data_i;
          cfpp_pkg::CFG_REMOTE_LO: rem_lo_q <= cfg_data_i;
          cfpp_pkg::CFG_SENSOR_HI: sen_hi_q <= cfg_data_i;
          cfpp_pkg::CFG_SENSOR_LO: sen_lo_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/cfpp_emitter.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cfpp_emitter (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  cfpp_pkg::cmd_t                  head_i,
  input  wire logic                       q_empty_i,
  output logic                            pop_o,
  output cfpp_pkg::ram_rd_t               ram_rd_o,
  input  wire logic [7:0]                 ram_rdata_i,
  output logic                            run_done_o,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [2:0]                      frame_status_o,
  output logic                            source_o,
  output logic [7:0]                      body_byte_o,
  output logic [cfpp_pkg::IDX_W-1:0]      byte_index_o,
  output logic                            last_of_run_o
);

  typedef enum logic [2:0] {
    E_IDLE = 3'b001,
    E_READ = 3'b010,
    E_LOAD = 3'b100
  } emit_state_e;

  emit_state_e                  state_q, state_d;
  logic                         src_q, src_d;
  logic                         bank_q, bank_d;
  logic [cfpp_pkg::CNT_W-1:0]   n_q, n_d;
  logic [cfpp_pkg::CNT_W-1:0]   idx_q, idx_d;
  logic                         last;
  logic                         out_free;
  logic                         load;
  logic                         valid_q, valid_d;
  cfpp_pkg::status_e            status_d, status_q;
  logic                         osrc_d, osrc_q;
  logic [7:0]                   byte_d, byte_q;
  logic [cfpp_pkg::IDX_W-1:0]   oidx_d, oidx_q;
  logic                         olast_d, olast_q;

  assign out_free = !valid_q || out_ready_i;
  assign last     = (idx_q == cfpp_pkg::CNT_W'(n_q - 1'b1));

  always_comb begin
    state_d    = state_q;
    src_d      = src_q;
    bank_d     = bank_q;
    n_d        = n_q;
    idx_d      = idx_q;
    pop_o      = 1'b0;
    run_done_o = 1'b0;
    load       = 1'b0;
    ram_rd_o   = '{re: 1'b0, addr: {bank_q, idx_q[cfpp_pkg::AW-1:0]}};
    status_d   = cfpp_pkg::ST_OK;
    osrc_d     = src_q;
    byte_d     = ram_rdata_i;
    oidx_d     = cfpp_pkg::IDX_W'(idx_q);
    olast_d    = last;
    case (state_q)
      E_IDLE: begin
        if (!q_empty_i) begin
          if (head_i.is_run) begin
            pop_o   = 1'b1;
            src_d   = head_i.src;
            bank_d  = head_i.bank;
            n_d     = head_i.count;
            idx_d   = '0;
            state_d = E_READ;
          end else if (out_free) begin
            // Error: one result, zero payload.
            pop_o    = 1'b1;
            load     = 1'b1;
            status_d = head_i.status;
            osrc_d   = 1'b0;
            byte_d   = '0;
            oidx_d   = '0;
            olast_d  = 1'b1;
          end
        end
      end
      E_READ: begin
        ram_rd_o.re = 1'b1;
        state_d     = E_LOAD;
      end
      E_LOAD: begin
        if (out_free) begin
          load = 1'b1;
          if (last) begin
            run_done_o = 1'b1;
            state_d    = E_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = E_READ;
          end
        end
      end
      default: begin
        state_d = E_IDLE;
      end
    endcase
  end

  always_comb begin
    valid_d = valid_q && !out_ready_i;
    if (load) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
      src_q   <= 1'b0;
      bank_q  <= 1'b0;
      n_q     <= '0;
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      src_q   <= src_d;
      bank_q  <= bank_d;
      n_q     <= n_d;
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q <= status_d;
      osrc_q   <= osrc_d;
      byte_q   <= byte_d;
      oidx_q   <= oidx_d;
      olast_q  <= olast_d;
    end
  end

  assign out_valid_o    = valid_q;
  assign frame_status_o = status_q;
  assign source_o       = osrc_q;
  assign body_byte_o    = byte_q;
  assign byte_index_o   = oidx_q;
  assign last_of_run_o  = olast_q;

endmodule

`default_nettype wire

// ===== sv/crc16_framed_packet_parser_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                 Payload
// cfg       in         cfg_valid_i / cfg_ready_o cfg_index_i[1:0], cfg_data_i[7:0]
// rx        in         in_valid_i / in_ready_o   rx_byte_i[7:0]
// result    out        out_valid_o / out_ready_i frame_status_o, source_o, body_byte_o,
//                                                byte_index_o, last_of_run_o
//
// The parser takes one received byte per cycle while in_ready_o is high; CRC, ID match
// and body store write all complete in the cycle the beat is taken.
// Each body result passes the emitter's read state (registered body RAM read), then
// its load state (output register load); an error result is loaded straight from idle.
// rx stalls while the two-entry command queue is full, or while a body byte
// would land in a RAM bank whose run is still waiting to be emitted.
// Reset clears control state only; the body RAM needs no clearing pass.
module crc16_framed_packet_parser_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [cfpp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [7:0]                     cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [7:0]                     rx_byte_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [2:0]                          frame_status_o,
  output logic                                source_o,
  output logic [7:0]                          body_byte_o,
  output logic [cfpp_pkg::IDX_W-1:0]          byte_index_o,
  output logic                                last_of_run_o
);

  // Front to back: one command per finished frame or detected fault.
  logic              q_push, q_full, q_pop, q_empty;
  cfpp_pkg::cmd_t    q_push_cmd, q_head;
  // Run completion releases a RAM bank back to the parser.
  logic              run_done;
  cfpp_pkg::ram_wr_t ram_wr;
  cfpp_pkg::ram_rd_t ram_rd;
  logic [7:0]        ram_rdata;

  // Front: sync hunt, length/ID checks, CRC, body capture into the open bank.
  cfpp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .push_o      (q_push),
    .push_cmd_o  (q_push_cmd),
    .q_full_i    (q_full),
    .run_done_i  (run_done),
    .ram_wr_o    (ram_wr)
  );

  cfpp_cmd_fifo u_cmd_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .head_o     (q_head),
    .empty_o    (q_empty)
  );

  // Two banks of BODY_DEPTH bytes: write side from the parser, read side from the emitter.
  cfpp_ram #(
    .WIDTH (8),
    .DEPTH (cfpp_pkg::RAM_DEPTH)
  ) u_body_ram (
    .clk_i   (clk_i),
    .we_i    (ram_wr.we),
    .waddr_i (ram_wr.addr),
    .wdata_i (ram_wr.data),
    .re_i    (ram_rd.re),
    .raddr_i (ram_rd.addr),
    .rdata_o (ram_rdata)
  );

  // Back: drain commands, walk the body bank, drive the output register.
  cfpp_emitter u_emitter (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (q_head),
    .q_empty_i      (q_empty),
    .pop_o          (q_pop),
    .ram_rd_o       (ram_rd),
    .ram_rdata_i    (ram_rdata),
    .run_done_o     (run_done),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .frame_status_o (frame_status_o),
    .source_o       (source_o),
    .body_byte_o    (body_byte_o),
    .byte_index_o   (byte_index_o),
    .last_of_run_o  (last_of_run_o)
  );

  // The parser never pushes into a full queue.
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_full))
    else $error("command pushed into full queue");

  // A body write never hits the entry the emitter is reading.
  a_bank_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_wr.we && ram_rd.re) |-> (ram_wr.addr[cfpp_pkg::RAM_AW-1] !=
                                  ram_rd.addr[cfpp_pkg::RAM_AW-1]))
    else $error("body write collides with bank under emission");

  // Error results carry a zero payload and close their run.
  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_status_o != cfpp_pkg::ST_OK) |->
      (last_of_run_o && !source_o && body_byte_o == 8'd0 && byte_index_o == '0))
    else $error("malformed error result");

  // A run completes only as its final good result is loaded, which then shows on the output.
  a_done_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_done |=> (out_valid_o && last_of_run_o && frame_status_o == cfpp_pkg::ST_OK))
    else $error("run finished without a final good result");

endmodule

`default_nettype wire
